/* rtl/core/mlk_pkg.sv */
// ----------------------------------------------------------------------------
// Morse LED keyer package
// Shared codes, command record and the Morse letter table.
// ----------------------------------------------------------------------------
package mlk_pkg;

	localparam int STORE_DEPTH_DEF = 256;
	localparam int TICK_WIDTH_DEF  = 16;

	localparam int NUM_REGS = 5;
	localparam int CFG_DW   = 16;
	localparam int CFG_IW   = 3;

	localparam int RST_DOT_TICKS  = 10 * 200;
	localparam int RST_DASH_TICKS = 10 * 400;
	localparam int RST_EGAP_TICKS = 10 * 200;
	localparam int RST_LGAP_TICKS = 10 * 400;
	localparam int RST_WGAP_TICKS = 10 * 600;

	// register indexes of the configuration port
	typedef enum logic [CFG_IW-1:0] {
		REG_DOT  = 3'd0,
		REG_DASH = 3'd1,
		REG_EGAP = 3'd2,
		REG_LGAP = 3'd3,
		REG_WGAP = 3'd4
	} reg_idx_t;

	localparam logic OP_TICK = 1'b1;

	localparam logic [7:0] CH_SPACE   = 8'h20;
	localparam logic [7:0] CH_SEMI    = 8'h3B;
	localparam logic [7:0] CH_UPPER_A = 8'h41;
	localparam logic [7:0] CH_UPPER_Z = 8'h5A;
	localparam logic [7:0] CH_LOWER_A = 8'h61;
	localparam logic [7:0] CH_LOWER_Z = 8'h7A;

	// element codes held in the store
	typedef enum logic [2:0] {
		EL_DOT  = 3'd1,
		EL_DASH = 3'd2,
		EL_EGAP = 3'd3,
		EL_LGAP = 3'd4,
		EL_WGAP = 3'd5
	} el_code_t;

	typedef enum logic [2:0] {
		CMD_TICK,
		CMD_START,
		CMD_SPACE,
		CMD_LETTER,
		CMD_OTHER
	} cmd_kind_t;

	// pattern bit k set: mark k is a dash
	typedef struct packed {
		logic [2:0] marks;
		logic [3:0] pattern;
	} morse_t;

	typedef struct packed {
		cmd_kind_t  kind;
		morse_t     code;
	} cmd_t;

	function automatic morse_t morse_lookup(input logic [4:0] idx);
		morse_t m;
		unique case (idx)
			5'd0:    m = '{marks: 3'd2, pattern: 4'b0010}; // A
			5'd1:    m = '{marks: 3'd4, pattern: 4'b0001}; // B
			5'd2:    m = '{marks: 3'd4, pattern: 4'b0101}; // C
			5'd3:    m = '{marks: 3'd3, pattern: 4'b0001}; // D
			5'd4:    m = '{marks: 3'd1, pattern: 4'b0000}; // E
			5'd5:    m = '{marks: 3'd4, pattern: 4'b0100}; // F
			5'd6:    m = '{marks: 3'd3, pattern: 4'b0011}; // G
			5'd7:    m = '{marks: 3'd4, pattern: 4'b0000}; // H
			5'd8:    m = '{marks: 3'd2, pattern: 4'b0000}; // I
			5'd9:    m = '{marks: 3'd4, pattern: 4'b1110}; // J
			5'd10:   m = '{marks: 3'd3, pattern: 4'b0101}; // K
			5'd11:   m = '{marks: 3'd4, pattern: 4'b0010}; // L
			5'd12:   m = '{marks: 3'd2, pattern: 4'b0011}; // M
			5'd13:   m = '{marks: 3'd2, pattern: 4'b0001}; // N
			5'd14:   m = '{marks: 3'd3, pattern: 4'b0111}; // O
			5'd15:   m = '{marks: 3'd4, pattern: 4'b0110}; // P
			5'd16:   m = '{marks: 3'd4, pattern: 4'b1011}; // Q
			5'd17:   m = '{marks: 3'd3, pattern: 4'b0010}; // R
			5'd18:   m = '{marks: 3'd3, pattern: 4'b0000}; // S
			5'd19:   m = '{marks: 3'd1, pattern: 4'b0001}; // T
			5'd20:   m = '{marks: 3'd3, pattern: 4'b0100}; // U
			5'd21:   m = '{marks: 3'd4, pattern: 4'b1000}; // V
			5'd22:   m = '{marks: 3'd3, pattern: 4'b0110}; // W
			5'd23:   m = '{marks: 3'd4, pattern: 4'b1001}; // X
			5'd24:   m = '{marks: 3'd4, pattern: 4'b1101}; // Y
			5'd25:   m = '{marks: 3'd4, pattern: 4'b0011}; // Z
			default: m = '{marks: 3'd1, pattern: 4'b0000};
		endcase
		return m;
	endfunction

endpackage

/* rtl/core/mlk_front.sv */
// ----------------------------------------------------------------------------
// Morse LED keyer front end
// Accepts input items and sorts them into tick, start, space, letter or other.
// ----------------------------------------------------------------------------
module mlk_front (
	input  logic          in_valid,
	output logic          in_ready,
	input  logic          opcode,
	input  logic [7:0]    char_code,
	input  logic          q_full,
	output logic          push,
	output mlk_pkg::cmd_t push_cmd
);
	import mlk_pkg::*;

	logic       is_upper;
	logic       is_lower;
	logic [4:0] letter_idx;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	assign is_upper = (char_code >= CH_UPPER_A) && (char_code <= CH_UPPER_Z);
	assign is_lower = (char_code >= CH_LOWER_A) && (char_code <= CH_LOWER_Z);

	always_comb begin
		letter_idx = is_upper ? 5'(char_code - CH_UPPER_A) : 5'(char_code - CH_LOWER_A);
		push_cmd.code = morse_lookup(letter_idx);
		if (opcode == OP_TICK) begin
			push_cmd.kind = CMD_TICK;
		end else if (char_code == CH_SEMI) begin
			push_cmd.kind = CMD_START;
		end else if (char_code == CH_SPACE) begin
			push_cmd.kind = CMD_SPACE;
		end else if (is_upper || is_lower) begin
			push_cmd.kind = CMD_LETTER;
		end else begin
			push_cmd.kind = CMD_OTHER;
		end
	end

endmodule

/* rtl/core/mlk_queue.sv */
// ----------------------------------------------------------------------------
// Morse LED keyer request queue
// Two-entry queue of classified requests between front end and back end.
// ----------------------------------------------------------------------------
module mlk_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  mlk_pkg::cmd_t push_cmd,
	output logic          full,
	input  logic          pop,
	output logic          valid,
	output mlk_pkg::cmd_t cmd
);
	import mlk_pkg::*;

	cmd_t       entries_q [2];
	logic       wr_ptr_q;
	logic       rd_ptr_q;
	logic [1:0] count_q;

	assign full  = (count_q == 2'd2);
	assign valid = (count_q != 2'd0);
	assign cmd   = entries_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entries_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_ptr_q <= !wr_ptr_q;
			end
			if (pop) begin
				rd_ptr_q <= !rd_ptr_q;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

/* rtl/core/mlk_back.sv */
// ----------------------------------------------------------------------------
// Morse LED keyer back end
// Element store, letter expansion, playback timer and result register.
// ----------------------------------------------------------------------------
module mlk_back #(
	parameter int STORE_DEPTH = mlk_pkg::STORE_DEPTH_DEF,
	parameter int TICK_WIDTH  = mlk_pkg::TICK_WIDTH_DEF
) (
	input  logic                                          clk,
	input  logic                                          arst_n,
	input  logic                                          q_valid,
	input  mlk_pkg::cmd_t                                 q_cmd,
	output logic                                          pop,
	input  logic [mlk_pkg::NUM_REGS-1:0][TICK_WIDTH-1:0]  dur_regs,
	output logic                                          out_valid,
	input  logic                                          out_ready,
	output logic                                          led_on,
	output logic                                          playing,
	output logic                                          finished,
	output logic                                          dropped
);
	import mlk_pkg::*;

	localparam int AW = $clog2(STORE_DEPTH);
	localparam int CW = $clog2(STORE_DEPTH + 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_WRITE,
		ST_ELEM
	} state_t;

	el_code_t elem_mem [STORE_DEPTH];
	el_code_t rd_data_q;

	state_t                state_q;
	logic [CW-1:0]         fill_q;
	logic [CW-1:0]         ptr_q;
	logic [TICK_WIDTH-1:0] ticks_q;
	logic                  led_q;
	logic                  active_q;
	logic [3:0]            wr_cnt_q;
	morse_t                letter_q;
	logic                  res_valid_q;
	logic                  res_led_q;
	logic                  res_play_q;
	logic                  res_fin_q;
	logic                  res_drop_q;

	logic                  slot_free;
	logic [TICK_WIDTH-1:0] tick_dec;
	logic                  tick_zero;
	logic                  has_elem;
	logic [CW-1:0]         room;
	logic [3:0]            need;
	logic                  wr_en;
	el_code_t              wr_data;
	logic                  rd_en;
	logic                  elem_led;
	logic [TICK_WIDTH-1:0] dur_sel;
	logic [TICK_WIDTH-1:0] dur_eff;

	assign out_valid = res_valid_q;
	assign led_on    = res_led_q;
	assign playing   = res_play_q;
	assign finished  = res_fin_q;
	assign dropped   = res_drop_q;

	assign slot_free = !res_valid_q || out_ready;
	assign pop       = (state_q == ST_IDLE) && q_valid && slot_free;

	assign tick_dec  = (ticks_q != '0) ? ticks_q - TICK_WIDTH'(1) : '0;
	assign tick_zero = (tick_dec == '0);
	assign has_elem  = (ptr_q < fill_q);
	assign room      = CW'(STORE_DEPTH) - fill_q;
	assign need      = {q_cmd.code.marks, 1'b1};

	assign rd_en = pop && (q_cmd.kind == CMD_TICK) && active_q && tick_zero && has_elem;

	always_comb begin
		wr_en   = 1'b0;
		wr_data = EL_WGAP;
		if (state_q == ST_WRITE) begin
			wr_en = 1'b1;
			if (wr_cnt_q == {letter_q.marks, 1'b0}) begin
				wr_data = EL_LGAP;
			end else if (wr_cnt_q[0]) begin
				wr_data = EL_EGAP;
			end else if (letter_q.pattern[wr_cnt_q[2:1]]) begin
				wr_data = EL_DASH;
			end else begin
				wr_data = EL_DOT;
			end
		end else if (pop && (q_cmd.kind == CMD_SPACE) && !active_q && (room != '0)) begin
			wr_en = 1'b1;
		end
	end

	// element just fetched from the store
	always_comb begin
		case (rd_data_q)
			EL_DOT: begin
				elem_led = 1'b1;
				dur_sel  = dur_regs[REG_DOT];
			end
			EL_DASH: begin
				elem_led = 1'b1;
				dur_sel  = dur_regs[REG_DASH];
			end
			EL_LGAP: begin
				elem_led = 1'b0;
				dur_sel  = dur_regs[REG_LGAP];
			end
			EL_WGAP: begin
				elem_led = 1'b0;
				dur_sel  = dur_regs[REG_WGAP];
			end
			default: begin
				elem_led = 1'b0;
				dur_sel  = dur_regs[REG_EGAP];
			end
		endcase
		dur_eff = (dur_sel == '0) ? TICK_WIDTH'(1) : dur_sel;
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			elem_mem[fill_q[AW-1:0]] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= elem_mem[ptr_q[AW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			fill_q      <= '0;
			ptr_q       <= '0;
			ticks_q     <= '0;
			led_q       <= 1'b0;
			active_q    <= 1'b0;
			wr_cnt_q    <= '0;
			letter_q    <= '0;
			res_valid_q <= 1'b0;
			res_led_q   <= 1'b0;
			res_play_q  <= 1'b0;
			res_fin_q   <= 1'b0;
			res_drop_q  <= 1'b0;
		end else begin
			if (res_valid_q && out_ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (pop) begin
						res_valid_q <= 1'b1;
						res_led_q   <= led_q;
						res_play_q  <= active_q;
						res_fin_q   <= 1'b0;
						res_drop_q  <= 1'b0;
						unique case (q_cmd.kind)
							CMD_TICK: begin
								if (active_q) begin
									if (!tick_zero) begin
										ticks_q <= tick_dec;
									end else if (has_elem) begin
										// hold the result until the element is fetched
										ticks_q     <= '0;
										res_valid_q <= 1'b0;
										state_q     <= ST_ELEM;
									end else begin
										active_q   <= 1'b0;
										led_q      <= 1'b0;
										fill_q     <= '0;
										ptr_q      <= '0;
										ticks_q    <= '0;
										res_led_q  <= 1'b0;
										res_play_q <= 1'b0;
										res_fin_q  <= 1'b1;
									end
								end
							end
							CMD_START: begin
								if (active_q) begin
									res_drop_q <= 1'b1;
								end else begin
									active_q   <= 1'b1;
									ptr_q      <= '0;
									ticks_q    <= '0;
									led_q      <= 1'b0;
									res_led_q  <= 1'b0;
									res_play_q <= 1'b1;
								end
							end
							CMD_SPACE: begin
								if (active_q || (room == '0)) begin
									res_drop_q <= 1'b1;
								end else begin
									fill_q <= fill_q + CW'(1);
								end
							end
							CMD_LETTER: begin
								if (active_q || (room < CW'(need))) begin
									res_drop_q <= 1'b1;
								end else begin
									wr_cnt_q <= '0;
									letter_q <= q_cmd.code;
									state_q  <= ST_WRITE;
								end
							end
							default: begin
								res_drop_q <= active_q;
							end
						endcase
					end
				end
				ST_WRITE: begin
					fill_q   <= fill_q + CW'(1);
					wr_cnt_q <= wr_cnt_q + 4'd1;
					if (wr_cnt_q == {letter_q.marks, 1'b0}) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ELEM: begin
					led_q       <= elem_led;
					ticks_q     <= dur_eff;
					ptr_q       <= ptr_q + CW'(1);
					res_valid_q <= 1'b1;
					res_led_q   <= elem_led;
					res_play_q  <= 1'b1;
					res_fin_q   <= 1'b0;
					res_drop_q  <= 1'b0;
					state_q     <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

/* rtl/core/morse_led_keyer_core.sv */
// ----------------------------------------------------------------------------
// Morse LED keyer core
// Turns message text into Morse elements and plays them on an LED level.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid/in_ready): opcode 0 carries a message character,
//   opcode 1 one timer tick. Every request gives exactly one result on the
//   output channel (out_valid/out_ready): LED level, playing, finished pulse
//   and dropped flag. Letters append their marks and gaps to the element
//   store, a space appends a word gap, ';' starts playback.
//   Configuration (cfg_valid/cfg_ready, cfg_index, cfg_data) sets the five
//   element durations in ticks; write it only while the core is idle.
// Timing:
//   The front end classifies in the accept cycle and hands the request to a
//   two-entry queue. The back end takes one request at a time: a tick that
//   fetches the next element passes through an element fetch state, and a
//   letter through a write state for its store writes, which follow its
//   result. A request passes the queue and the result register to out_valid.
// Reset: store empty, playback idle, LED off, durations 2000/4000/2000/
//   4000/6000 ticks. No clearing pass is needed.
// Stall: the result register holds until taken; the queue keeps accepting
//   until both entries are full, then in_ready drops.
// ----------------------------------------------------------------------------
module morse_led_keyer_core #(
	parameter int STORE_DEPTH = mlk_pkg::STORE_DEPTH_DEF,
	parameter int TICK_WIDTH  = mlk_pkg::TICK_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic                       opcode,
	input  logic [7:0]                 char_code,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic                       led_on,
	output logic                       playing,
	output logic                       finished,
	output logic                       dropped,
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [mlk_pkg::CFG_IW-1:0] cfg_index,
	input  logic [mlk_pkg::CFG_DW-1:0] cfg_data
);
	import mlk_pkg::*;

	logic [NUM_REGS-1:0][TICK_WIDTH-1:0] dur_regs_q;

	logic q_full;
	logic push;
	cmd_t push_cmd;
	logic pop;
	logic q_valid;
	cmd_t q_cmd;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dur_regs_q[REG_DOT]  <= TICK_WIDTH'(RST_DOT_TICKS);
			dur_regs_q[REG_DASH] <= TICK_WIDTH'(RST_DASH_TICKS);
			dur_regs_q[REG_EGAP] <= TICK_WIDTH'(RST_EGAP_TICKS);
			dur_regs_q[REG_LGAP] <= TICK_WIDTH'(RST_LGAP_TICKS);
			dur_regs_q[REG_WGAP] <= TICK_WIDTH'(RST_WGAP_TICKS);
		end else if (cfg_valid) begin
			// drop writes beyond the register list
			case (cfg_index)
				REG_DOT:  dur_regs_q[REG_DOT]  <= TICK_WIDTH'(cfg_data);
				REG_DASH: dur_regs_q[REG_DASH] <= TICK_WIDTH'(cfg_data);
				REG_EGAP: dur_regs_q[REG_EGAP] <= TICK_WIDTH'(cfg_data);
				REG_LGAP: dur_regs_q[REG_LGAP] <= TICK_WIDTH'(cfg_data);
				REG_WGAP: dur_regs_q[REG_WGAP] <= TICK_WIDTH'(cfg_data);
				default: begin
				end
			endcase
		end
	end

	mlk_front u_front (
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.char_code (char_code),
		.q_full    (q_full),
		.push      (push),
		.push_cmd  (push_cmd)
	);

	mlk_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.valid    (q_valid),
		.cmd      (q_cmd)
	);

	mlk_back #(
		.STORE_DEPTH (STORE_DEPTH),
		.TICK_WIDTH  (TICK_WIDTH)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.q_cmd     (q_cmd),
		.pop       (pop),
		.dur_regs  (dur_regs_q),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.led_on    (led_on),
		.playing   (playing),
		.finished  (finished),
		.dropped   (dropped)
	);

	a_fin_stops: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && finished |-> !playing && !led_on)
		else $error("finished result with playback still running");

	a_led_needs_play: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && led_on |-> playing)
		else $error("LED lit outside playback");

	a_fin_not_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(finished && dropped))
		else $error("result both finished and dropped");

	a_pop_needs_slot: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> !(out_valid && $past(out_valid) && !$past(out_ready) && !$stable(led_on)))
		else $error("result overwritten while stalled");

endmodule

/* tb/tb_morse_led_keyer_core.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Morse LED keyer core testbench
// Feeds message characters and timer ticks through the request channel and
// checks every result against a cycle-free model of the keyer. Covers the
// zero duration setting, ignored and dropped characters, an element store
// filled to its last entry and back-pressure on both sides.
// ----------------------------------------------------------------------------
module tb_morse_led_keyer_core;
	import mlk_pkg::*;

	localparam int   KEYER_DEPTH   = STORE_DEPTH_DEF;
	localparam logic OP_CHAR       = 1'b0;
	localparam int   SETTLE_CYCLES = 14;
	localparam int   HOLD_CYCLES   = 300;
	localparam int   STALL_LIMIT   = 4000;
	localparam int   RANDOM_REQS   = 160;

	typedef struct packed {
		logic       op;
		logic [7:0] ch;
	} keyer_req_t;

	typedef struct packed {
		logic led;
		logic playing;
		logic finished;
		logic dropped;
	} keyer_res_t;

	logic              clk       = 1'b0;
	logic              arst_n    = 1'b0;
	logic              in_valid  = 1'b0;
	logic              in_ready;
	logic              opcode    = OP_CHAR;
	logic [7:0]        char_code = 8'h00;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              led_on;
	logic              playing;
	logic              finished;
	logic              dropped;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [CFG_IW-1:0] cfg_index = '0;
	logic [CFG_DW-1:0] cfg_data  = '0;

	morse_led_keyer_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.opcode    (opcode),
		.char_code (char_code),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.led_on    (led_on),
		.playing   (playing),
		.finished  (finished),
		.dropped   (dropped),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// keyer model state
	logic [2:0]        el_store [KEYER_DEPTH];
	int                fill_cnt;
	int                play_ptr;
	logic [15:0]       ticks_rem;
	logic              led_lvl;
	logic              play_on;
	logic [CFG_DW-1:0] dur_reg [NUM_REGS];

	keyer_req_t pending_reqs[$];
	keyer_res_t keyer_outs_due[$];
	keyer_req_t tx_req;
	keyer_res_t rx_got;
	keyer_res_t rx_want;
	logic       keyer_busy_q = 1'b0;

	int n_queued     = 0;
	int n_taken      = 0;
	int n_checked    = 0;
	int n_errors     = 0;
	int n_drops      = 0;
	int n_finishes   = 0;
	int n_messages   = 0;
	int n_settings   = 0;
	int n_model_ends = 0;
	int tx_idle_pct  = 0;
	int rx_stall_pct = 0;
	int hold_left    = 0;
	logic hold_kick  = 1'b0;
	int stall_cnt    = 0;

	initial begin
		forever #1 clk = ~clk;
	end

	function automatic string morse_of(int slot);
		case (slot)
			0: return ".-";     1: return "-...";   2: return "-.-.";   3: return "-..";
			4: return ".";      5: return "..-.";   6: return "--.";    7: return "....";
			8: return "..";     9: return ".---";   10: return "-.-";   11: return ".-..";
			12: return "--";    13: return "-.";    14: return "---";   15: return ".--.";
			16: return "--.-";  17: return ".-.";   18: return "...";   19: return "-";
			20: return "..-";   21: return "...-";  22: return ".--";   23: return "-..-";
			24: return "-.--";  25: return "--..";
			default: return "";
		endcase
	endfunction

	// advance the keyer model by one request and return the result it gives
	function automatic keyer_res_t next_keyer_output(keyer_req_t rq);
		keyer_res_t  r;
		string       pat;
		int          slot;
		logic [15:0] dur;
		r = '0;
		slot = -1;
		if (rq.ch >= CH_UPPER_A && rq.ch <= CH_UPPER_Z)
			slot = rq.ch - CH_UPPER_A;
		else if (rq.ch >= CH_LOWER_A && rq.ch <= CH_LOWER_Z)
			slot = rq.ch - CH_LOWER_A;
		if (rq.op != OP_TICK) begin
			if (play_on) begin
				r.dropped = 1'b1;
			end else if (rq.ch == CH_SEMI) begin
				play_on   = 1'b1;
				play_ptr  = 0;
				ticks_rem = '0;
				led_lvl   = 1'b0;
			end else if (rq.ch == CH_SPACE) begin
				if (fill_cnt >= KEYER_DEPTH) begin
					r.dropped = 1'b1;
				end else begin
					el_store[fill_cnt] = EL_WGAP;
					fill_cnt++;
				end
			end else if (slot >= 0) begin
				pat = morse_of(slot);
				// a letter goes in whole or not at all
				if (KEYER_DEPTH - fill_cnt < 2 * pat.len() + 1) begin
					r.dropped = 1'b1;
				end else begin
					for (int k = 0; k < pat.len(); k++) begin
						el_store[fill_cnt]     = (pat[k] == "-") ? EL_DASH : EL_DOT;
						el_store[fill_cnt + 1] = EL_EGAP;
						fill_cnt += 2;
					end
					el_store[fill_cnt] = EL_LGAP;
					fill_cnt++;
				end
			end
		end else if (play_on) begin
			if (ticks_rem != 0)
				ticks_rem = ticks_rem - 16'd1;
			if (ticks_rem == 0) begin
				if (play_ptr < fill_cnt) begin
					case (el_code_t'(el_store[play_ptr]))
						EL_DOT: begin
							led_lvl = 1'b1;
							dur = dur_reg[REG_DOT];
						end
						EL_DASH: begin
							led_lvl = 1'b1;
							dur = dur_reg[REG_DASH];
						end
						EL_LGAP: begin
							led_lvl = 1'b0;
							dur = dur_reg[REG_LGAP];
						end
						EL_WGAP: begin
							led_lvl = 1'b0;
							dur = dur_reg[REG_WGAP];
						end
						default: begin
							led_lvl = 1'b0;
							dur = dur_reg[REG_EGAP];
						end
					endcase
					play_ptr++;
					ticks_rem = (dur == 0) ? 16'd1 : dur;
				end else begin
					play_on    = 1'b0;
					led_lvl    = 1'b0;
					r.finished = 1'b1;
					fill_cnt   = 0;
					play_ptr   = 0;
					ticks_rem  = '0;
					n_model_ends++;
				end
			end
		end
		r.led     = led_lvl;
		r.playing = play_on;
		return r;
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid  <= 1'b0;
			opcode    <= OP_CHAR;
			char_code <= 8'h00;
		end else begin
			if (in_valid && in_ready) begin
				keyer_outs_due.push_back(next_keyer_output(tx_req));
				n_taken <= n_taken + 1;
			end
			if (!in_valid || in_ready) begin
				if (pending_reqs.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
					tx_req = pending_reqs.pop_front();
					in_valid  <= 1'b1;
					opcode    <= tx_req.op;
					char_code <= tx_req.ch;
				end else begin
					in_valid <= 1'b0;
				end
			end
			keyer_busy_q <= play_on;
		end
	end

	task automatic check_bit(input string field, input logic want, input logic got);
		if (want !== got) begin
			$display("%0t: %s mismatch, expected %0b, got %0b", $time, field, want, got);
			n_errors++;
		end
	endtask

	// result monitor
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				rx_got = {led_on, playing, finished, dropped};
				if (keyer_outs_due.size() == 0) begin
					$display("%0t: unexpected result, expected none, got %b", $time, rx_got);
					n_errors++;
				end else begin
					rx_want = keyer_outs_due.pop_front();
					check_bit("led_on", rx_want.led, rx_got.led);
					check_bit("playing", rx_want.playing, rx_got.playing);
					check_bit("finished", rx_want.finished, rx_got.finished);
					check_bit("dropped", rx_want.dropped, rx_got.dropped);
					n_checked++;
				end
				if (dropped)
					n_drops++;
				if (finished)
					n_finishes++;
			end
			out_ready <= (hold_left == 0) && ($urandom_range(99) >= rx_stall_pct);
		end
	end

	// long receiver hold-off
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			hold_left <= 0;
		else if (hold_kick && hold_left == 0)
			hold_left <= HOLD_CYCLES;
		else if (hold_left != 0)
			hold_left <= hold_left - 1;
	end

	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
				(cfg_valid && cfg_ready)) begin
			stall_cnt <= 0;
		end else if (stall_cnt >= STALL_LIMIT) begin
			$display("%0t: no handshake for %0d cycles", $time, STALL_LIMIT);
			$display("tb_morse_led_keyer_core: done, errors");
			$finish;
		end else begin
			stall_cnt <= stall_cnt + 1;
		end
	end

	task automatic push_req(input logic op, input logic [7:0] ch);
		keyer_req_t rq;
		rq.op = op;
		rq.ch = ch;
		pending_reqs.push_back(rq);
		n_queued++;
	endtask

	// hold until every request is taken and every result has come back
	task automatic wait_drain();
		do @(negedge clk);
		while (n_taken != n_queued || keyer_outs_due.size() != 0);
	endtask

	task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx < NUM_REGS)
			dur_reg[idx] = val;
	endtask

	task automatic set_durations(input logic [15:0] d_dot, d_dash, d_egap, d_lgap, d_wgap);
		wait_drain();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(REG_DOT, d_dot);
		write_reg(REG_DASH, d_dash);
		write_reg(REG_EGAP, d_egap);
		write_reg(REG_LGAP, d_lgap);
		write_reg(REG_WGAP, d_wgap);
		// an index past the register list must change nothing
		write_reg(CFG_IW'($urandom_range((1 << CFG_IW) - 1, NUM_REGS)), CFG_DW'($urandom));
		n_settings++;
		@(negedge clk);
	endtask

	function automatic logic [15:0] rand_dur();
		int pick;
		pick = $urandom_range(99);
		if (pick < 8)
			return 16'd0;
		else if (pick < 16)
			return 16'($urandom_range(8, 4));
		return 16'($urandom_range(3, 1));
	endfunction

	task automatic compose(input int n_chars, input int junk_pct);
		int pick;
		for (int i = 0; i < n_chars; i++) begin
			pick = $urandom_range(99);
			if (pick < junk_pct)
				push_req(OP_CHAR, 8'($urandom));
			else if (pick < junk_pct + 15)
				push_req(OP_CHAR, CH_SPACE);
			else
				push_req(OP_CHAR, ($urandom_range(1) ? CH_UPPER_A : CH_LOWER_A) +
						8'($urandom_range(25)));
		end
	endtask

	// start playback, then feed ticks, with some random characters mixed in, until the model reports it stopped
	task automatic play_out(input int noise_pct);
		int ends_at_start;
		ends_at_start = n_model_ends;
		push_req(OP_CHAR, CH_SEMI);
		n_messages++;
		forever begin
			@(negedge clk);
			if (n_taken == n_queued && !keyer_busy_q)
				break;
			// stop feeding once playback has ended, unless a stray ';' restarted it
			if (pending_reqs.size() < 3 &&
					(keyer_busy_q || n_model_ends == ends_at_start)) begin
				if ($urandom_range(99) < noise_pct)
					push_req(OP_CHAR, 8'($urandom));
				else
					push_req(OP_TICK, 8'($urandom));
			end
		end
	endtask

	initial begin
		int tx_pct [4];
		int rx_pct [4];
		int phase_start;
		int len;
		tx_pct = '{0, 55, 0, 18};
		rx_pct = '{0, 0, 55, 18};
		fill_cnt  = 0;
		play_ptr  = 0;
		ticks_rem = '0;
		led_lvl   = 1'b0;
		play_on   = 1'b0;
		dur_reg[REG_DOT]  = CFG_DW'(RST_DOT_TICKS);
		dur_reg[REG_DASH] = CFG_DW'(RST_DASH_TICKS);
		dur_reg[REG_EGAP] = CFG_DW'(RST_EGAP_TICKS);
		dur_reg[REG_LGAP] = CFG_DW'(RST_LGAP_TICKS);
		dur_reg[REG_WGAP] = CFG_DW'(RST_WGAP_TICKS);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// idle tick, characters just outside the letter ranges, then one letter
		push_req(OP_TICK, 8'hFF);
		push_req(OP_CHAR, 8'h00);
		push_req(OP_CHAR, CH_UPPER_A - 8'd1);
		push_req(OP_CHAR, CH_UPPER_Z + 8'd1);
		push_req(OP_CHAR, CH_LOWER_A - 8'd1);
		push_req(OP_CHAR, CH_LOWER_Z + 8'd1);
		push_req(OP_CHAR, 8'hFF);
		push_req(OP_CHAR, CH_UPPER_A + 8'd4);

		set_durations(16'd1, 16'd2, 16'd1, 16'd3, 16'd4);
		push_req(OP_CHAR, CH_UPPER_A);
		push_req(OP_CHAR, CH_UPPER_Z);
		push_req(OP_CHAR, CH_LOWER_A);
		push_req(OP_CHAR, CH_LOWER_Z);
		push_req(OP_CHAR, CH_SPACE);
		play_out(25);
		// start with nothing stored
		play_out(0);

		// zero durations; fill the store to its last entry with H (nine
		// entries each) and spaces, one of each refused for lack of room
		set_durations(16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		for (int i = 0; i <= KEYER_DEPTH / 9; i++)
			push_req(OP_CHAR, CH_UPPER_A + 8'd7);
		for (int i = 0; i <= KEYER_DEPTH % 9; i++)
			push_req(OP_CHAR, CH_SPACE);
		play_out(0);

		for (int ph = 0; ph < 4; ph++) begin
			wait_drain();
			tx_idle_pct  = tx_pct[ph];
			rx_stall_pct = rx_pct[ph];
			set_durations(rand_dur(), rand_dur(), rand_dur(), rand_dur(), rand_dur());
			phase_start = n_queued;
			while (n_queued - phase_start < RANDOM_REQS / 4) begin
				wait_drain();
				len = $urandom_range(4, 1);
				if (ph == 2 && n_queued == phase_start) begin
					@(posedge clk);
					hold_kick <= 1'b1;
					@(posedge clk);
					hold_kick <= 1'b0;
					compose(8, 5);
				end else begin
					compose(len, 8);
				end
				// sometimes let the next message pile onto this one
				if ($urandom_range(99) < 80)
					play_out($urandom_range(10));
			end
		end

		wait_drain();
		repeat (30) @(posedge clk);
		if (keyer_outs_due.size() != 0) begin
			$display("%0t: %0d results never arrived", $time, keyer_outs_due.size());
			n_errors++;
		end
		$display("tb_morse_led_keyer_core: %0d requests, %0d results checked, %0d messages played",
				n_queued, n_checked, n_messages);
		$display("tb_morse_led_keyer_core: %0d drops, %0d end pulses, %0d duration settings",
				n_drops, n_finishes, n_settings);
		if (n_errors == 0)
			$display("tb_morse_led_keyer_core: done, clean");
		else
			$display("tb_morse_led_keyer_core: done, errors");
		$finish;
	end

endmodule
